[rtl/cnpp_pkg.sv]
// Package for the curve next-point predictor.
// Holds the channel payload types, operation and mode codes, and fixed-point constants.
// No dependencies.
package cnpp_pkg;

  localparam int HIST_DEPTH = 3;
  localparam int STEP_W     = 12;

  localparam logic [STEP_W-1:0] STEP_RESET = 12'd10;

  localparam logic [1:0] OP_BEGIN     = 2'd0;
  localparam logic [1:0] OP_CLICK     = 2'd1;
  localparam logic [1:0] OP_REPREDICT = 2'd2;
  localparam logic [1:0] OP_FINISH    = 2'd3;

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_WAIT  = 2'd1;
  localparam logic [1:0] MODE_ANNOT = 2'd2;

  localparam logic signed [15:0] ONE_Q14    = 16'sd16384;
  localparam logic signed [15:0] AXIS_LIMIT = 16'sd14745;
  localparam logic signed [63:0] UP_MIN_SQ  = 64'sd65536;
  localparam logic signed [32:0] ONE_Q28    = 33'sd268435456;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic               primary_button;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [15:0] seed_normal_x;
    logic signed [15:0] seed_normal_y;
    logic signed [15:0] seed_normal_z;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic               prediction_valid;
    logic signed [31:0] next_x;
    logic signed [31:0] next_y;
    logic signed [31:0] next_z;
    logic signed [15:0] heading_x;
    logic signed [15:0] heading_y;
    logic signed [15:0] heading_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
  } out_item_t;

endpackage

[rtl/curve_next_point_predictor.sv]
// Curve next-point predictor: top level and its whole datapath.
// Depends on cnpp_pkg (payload types, codes, constants).
//
// Tracks a 3D curve from clicked points and predicts the next point one step_length away,
// with a unit heading and an up vector kept orthogonal to it. One item is in work at a time;
// in_ready is high only while the sequencer is idle. Most of the work per item is in the vector
// normalizer, which runs up to four times per item: a 32-step square root and three 15-step
// restoring divisions, plus a shift loop. All products go through one registered 33x33
// multiplier with an accumulator; each term is multiplied, then accumulated.
// The result sits in an output register, so the next item is taken while it waits.
module curve_next_point_predictor (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  cnpp_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output cnpp_pkg::out_item_t             out_data,
  input  logic                            cfg_wr_en,
  input  logic [cnpp_pkg::STEP_W-1:0]     cfg_wr_data
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_MAC     = 5'd1;
  localparam logic [4:0] S_NLOAD   = 5'd2;
  localparam logic [4:0] S_NSHIFT  = 5'd3;
  localparam logic [4:0] S_NSQI    = 5'd4;
  localparam logic [4:0] S_NSQRT   = 5'd5;
  localparam logic [4:0] S_NDIVLD  = 5'd6;
  localparam logic [4:0] S_NDIV    = 5'd7;
  localparam logic [4:0] S_FCAX    = 5'd8;
  localparam logic [4:0] S_FCAXN   = 5'd9;
  localparam logic [4:0] S_PRED    = 5'd10;
  localparam logic [4:0] S_PVN     = 5'd11;
  localparam logic [4:0] S_PVFIX   = 5'd12;
  localparam logic [4:0] S_PWN     = 5'd13;
  localparam logic [4:0] S_PWFIX   = 5'd14;
  localparam logic [4:0] S_STEP    = 5'd15;
  localparam logic [4:0] S_STEPFIN = 5'd16;
  localparam logic [4:0] S_DOT     = 5'd17;
  localparam logic [4:0] S_UPV     = 5'd18;
  localparam logic [4:0] S_UPSQ    = 5'd19;
  localparam logic [4:0] S_UPCHK   = 5'd20;
  localparam logic [4:0] S_AXN     = 5'd21;
  localparam logic [4:0] S_OUT     = 5'd22;

  localparam logic [2:0] MOP_BLDV = 3'd0;
  localparam logic [2:0] MOP_BLDW = 3'd1;
  localparam logic [2:0] MOP_DOT  = 3'd2;
  localparam logic [2:0] MOP_UPV  = 3'd3;
  localparam logic [2:0] MOP_UPSQ = 3'd4;
  localparam logic [2:0] MOP_AXIS = 3'd5;
  localparam logic [2:0] MOP_NSQ  = 3'd6;
  localparam logic [2:0] MOP_STEP = 3'd7;

  localparam logic [1:0] DST_HD = 2'd0;
  localparam logic [1:0] DST_UV = 2'd1;
  localparam logic [1:0] DST_UP = 2'd2;

  function automatic logic signed [31:0] comp(input cnpp_pkg::point_t p, input logic [1:0] c);
    logic signed [31:0] v;
    unique case (c)
      2'd0:    v = p.x;
      2'd1:    v = p.y;
      default: v = p.z;
    endcase
    return v;
  endfunction

  // control
  logic [4:0]                  state_r, state_nxt, ret_r, ret_nxt, nret_r, nret_nxt;
  logic [1:0]                  mode_r, mode_nxt, cnt_r, cnt_nxt;
  logic [cnpp_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [2:0]                  mop_r, mop_nxt;
  logic [1:0]                  ci_r, ci_nxt, tc_r, tc_nxt, ndst_r, ndst_nxt;
  logic                        ph_r, ph_nxt, nz_r, nz_nxt;
  logic                        racc_r, racc_nxt, rvld_r, rvld_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic signed [15:0]          seed_r [3];
  logic signed [15:0]          seed_nxt [3];
  logic signed [15:0]          up_r [3];
  logic signed [15:0]          up_nxt [3];

  // payload
  cnpp_pkg::point_t            hist_r [cnpp_pkg::HIST_DEPTH];
  cnpp_pkg::point_t            hist_nxt [cnpp_pkg::HIST_DEPTH];
  logic signed [15:0]          hd_r [3];
  logic signed [15:0]          hd_nxt [3];
  logic signed [15:0]          uv_r [3];
  logic signed [15:0]          uv_nxt [3];
  logic signed [31:0]          nx_r [3];
  logic signed [31:0]          nx_nxt [3];
  logic signed [47:0]          nv_r [3];
  logic signed [47:0]          nv_nxt [3];
  logic [47:0]                 na_r [3];
  logic [47:0]                 na_nxt [3];
  logic                        ns_r [3];
  logic                        ns_nxt [3];
  logic signed [63:0]          prod_r, prod_nxt, acc_r, acc_nxt;
  logic signed [31:0]          dot_r, dot_nxt;
  logic [63:0]                 sx_r, sx_nxt, res_r, res_nxt;
  logic [4:0]                  k_r, k_nxt;
  logic [31:0]                 rr_r, rr_nxt, rem_r, rem_nxt;
  logic [14:0]                 nlo_r, nlo_nxt, q_r, q_nxt;
  logic [3:0]                  j_r, j_nxt;
  logic signed [21:0]          off_r, off_nxt;
  cnpp_pkg::out_item_t         out_r, out_nxt;

  // datapath temporaries
  logic [1:0]                  hidx, axc;
  logic signed [31:0]          hcomp;
  logic signed [15:0]          hd_c;
  logic signed [32:0]          mul_a, mul_b;
  logic signed [65:0]          mul_p;
  logic [1:0]                  nlast;
  logic                        per_comp, clr;
  logic signed [63:0]          acc_sum;
  logic [47:0]                 upm, m01, mx, pm;
  logic [63:0]                 bitv, tsum;
  logic [44:0]                 nn;
  logic [32:0]                 rem2;
  logic                        ge;
  logic [15:0]                 qv;
  logic signed [15:0]          wv;
  logic [20:0]                 qr;
  logic signed [33:0]          ssum;
  logic signed [15:0]          hfix [3];
  cnpp_pkg::point_t            pin;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    if (state_r == S_STEPFIN) begin
      hidx = cnt_r - 2'd1;
    end else if (mop_r == MOP_BLDV && cnt_r == 2'd2) begin
      hidx = (tc_r == 2'd0) ? 2'd1 : 2'd0;
    end else begin
      hidx = tc_r;
    end
    hcomp = comp(hist_r[hidx], ci_r);
    axc   = (hd_r[1] <= cnpp_pkg::AXIS_LIMIT && hd_r[1] >= -cnpp_pkg::AXIS_LIMIT) ? 2'd1 : 2'd0;
    hd_c  = (axc == 2'd1) ? hd_r[1] : hd_r[0];
    upm   = nv_r[ci_r][47] ? 48'(-nv_r[ci_r]) : 48'(nv_r[ci_r]);
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    nlast    = 2'd0;
    per_comp = 1'b1;
    unique case (mop_r)
      MOP_BLDV: begin
        if (cnt_r == 2'd3) begin
          mul_a = 33'(hcomp);
          mul_b = (tc_r == 2'd0) ? 33'sd3 : ((tc_r == 2'd1) ? -33'sd8 : 33'sd5);
          nlast = 2'd2;
        end else if (cnt_r == 2'd2) begin
          mul_a = 33'(hcomp);
          mul_b = (tc_r == 2'd0) ? 33'sd1 : -33'sd1;
          nlast = 2'd1;
        end else begin
          mul_a = 33'(seed_r[ci_r]);
          mul_b = 33'sd1;
        end
      end
      MOP_BLDW: begin
        mul_a = 33'(hcomp);
        mul_b = (tc_r == 2'd0) ? 33'sd1 : ((tc_r == 2'd1) ? -33'sd3 : 33'sd2);
        nlast = 2'd2;
      end
      MOP_DOT: begin
        mul_a    = 33'(up_r[ci_r]);
        mul_b    = 33'(hd_r[ci_r]);
        per_comp = 1'b0;
      end
      MOP_UPV: begin
        mul_a = (tc_r == 2'd0) ? 33'(up_r[ci_r]) : 33'(dot_r);
        mul_b = (tc_r == 2'd0) ? cnpp_pkg::ONE_Q28 : -33'(hd_r[ci_r]);
        nlast = 2'd1;
      end
      MOP_UPSQ: begin
        mul_a    = {1'b0, upm[45:14]};
        mul_b    = {1'b0, upm[45:14]};
        per_comp = 1'b0;
      end
      MOP_AXIS: begin
        if (tc_r == 2'd0) begin
          mul_a = (ci_r == axc) ? cnpp_pkg::ONE_Q28 : 33'sd0;
          mul_b = 33'sd1;
        end else begin
          mul_a = 33'(hd_c);
          mul_b = -33'(hd_r[ci_r]);
        end
        nlast = 2'd1;
      end
      MOP_NSQ: begin
        mul_a    = {1'b0, na_r[ci_r][31:0]};
        mul_b    = {1'b0, na_r[ci_r][31:0]};
        per_comp = 1'b0;
      end
      MOP_STEP: begin
        mul_a = 33'(uv_r[ci_r]);
        mul_b = {21'd0, step_r};
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    nret_nxt      = nret_r;
    mode_nxt      = mode_r;
    cnt_nxt       = cnt_r;
    step_nxt      = cfg_wr_en ? cfg_wr_data : step_r;
    mop_nxt       = mop_r;
    ci_nxt        = ci_r;
    tc_nxt        = tc_r;
    ndst_nxt      = ndst_r;
    ph_nxt        = ph_r;
    nz_nxt        = nz_r;
    racc_nxt      = racc_r;
    rvld_nxt      = rvld_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_nxt       = out_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    dot_nxt       = dot_r;
    sx_nxt        = sx_r;
    res_nxt       = res_r;
    k_nxt         = k_r;
    rr_nxt        = rr_r;
    rem_nxt       = rem_r;
    nlo_nxt       = nlo_r;
    q_nxt         = q_r;
    j_nxt         = j_r;
    off_nxt       = off_r;
    for (int i = 0; i < 3; i++) begin
      seed_nxt[i] = seed_r[i];
      up_nxt[i]   = up_r[i];
      hd_nxt[i]   = hd_r[i];
      uv_nxt[i]   = uv_r[i];
      nx_nxt[i]   = nx_r[i];
      nv_nxt[i]   = nv_r[i];
      na_nxt[i]   = na_r[i];
      ns_nxt[i]   = ns_r[i];
      hfix[i]     = hd_r[i];
    end
    for (int i = 0; i < cnpp_pkg::HIST_DEPTH; i++) begin
      hist_nxt[i] = hist_r[i];
    end
    clr     = 1'b0;
    acc_sum = '0;
    m01     = (na_r[0] > na_r[1]) ? na_r[0] : na_r[1];
    mx      = (m01 > na_r[2]) ? m01 : na_r[2];
    bitv    = 64'd1 << {k_r, 1'b0};
    tsum    = res_r + bitv;
    nn      = 45'({na_r[ci_r][29:0], 14'd0}) + 45'(rr_r[31:1]);
    rem2    = {rem_r, nlo_r[j_r]};
    ge      = (rem2 >= {1'b0, rr_r});
    qv      = '0;
    wv      = '0;
    pm      = nv_r[ci_r][47] ? 48'(-nv_r[ci_r]) : 48'(nv_r[ci_r]);
    qr      = 21'((pm[26:0] + 27'd32) >> 6);
    ssum    = 34'(hcomp) + 34'(off_r);
    pin.x   = in_data.point_x;
    pin.y   = in_data.point_y;
    pin.z   = in_data.point_z;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          racc_nxt  = 1'b0;
          rvld_nxt  = 1'b0;
          state_nxt = S_OUT;
          unique case (in_data.operation)
            cnpp_pkg::OP_BEGIN: begin
              mode_nxt = cnpp_pkg::MODE_WAIT;
              cnt_nxt  = 2'd0;
              racc_nxt = 1'b1;
            end
            cnpp_pkg::OP_CLICK: begin
              if (in_data.primary_button && (mode_r == cnpp_pkg::MODE_WAIT ||
                                             mode_r == cnpp_pkg::MODE_ANNOT)) begin
                racc_nxt = 1'b1;
                rvld_nxt = 1'b1;
                // drop the oldest point once the history is full
                if (cnt_r == 2'd3) begin
                  hist_nxt[0] = hist_r[1];
                  hist_nxt[1] = hist_r[2];
                  hist_nxt[2] = pin;
                end else begin
                  hist_nxt[cnt_r] = pin;
                  cnt_nxt         = cnt_r + 2'd1;
                end
                if (mode_r == cnpp_pkg::MODE_WAIT) begin
                  seed_nxt[0] = in_data.seed_normal_x;
                  seed_nxt[1] = in_data.seed_normal_y;
                  seed_nxt[2] = in_data.seed_normal_z;
                  nv_nxt[0]   = 48'(in_data.seed_normal_x);
                  nv_nxt[1]   = 48'(in_data.seed_normal_y);
                  nv_nxt[2]   = 48'(in_data.seed_normal_z);
                  mode_nxt    = cnpp_pkg::MODE_ANNOT;
                  ndst_nxt    = DST_HD;
                  nret_nxt    = S_FCAX;
                  state_nxt   = S_NLOAD;
                end else begin
                  state_nxt = S_PRED;
                end
              end
            end
            cnpp_pkg::OP_REPREDICT: begin
              if (mode_r == cnpp_pkg::MODE_ANNOT && cnt_r != 2'd0) begin
                racc_nxt  = 1'b1;
                rvld_nxt  = 1'b1;
                state_nxt = S_PRED;
              end
            end
            cnpp_pkg::OP_FINISH: begin
              if (mode_r == cnpp_pkg::MODE_WAIT || mode_r == cnpp_pkg::MODE_ANNOT) begin
                mode_nxt = cnpp_pkg::MODE_IDLE;
                cnt_nxt  = 2'd0;
                racc_nxt = 1'b1;
              end
            end
          endcase
        end
      end

      // each term: multiply into the product register, then accumulate
      S_MAC: begin
        if (!ph_r) begin
          prod_nxt = mul_p[63:0];
          ph_nxt   = 1'b1;
        end else begin
          ph_nxt  = 1'b0;
          clr     = (tc_r == 2'd0) && (per_comp || ci_r == 2'd0);
          acc_sum = (clr ? 64'sd0 : acc_r) + prod_r;
          acc_nxt = acc_sum;
          if (tc_r == nlast) begin
            tc_nxt = 2'd0;
            if (per_comp) begin
              nv_nxt[ci_r] = acc_sum[47:0];
            end
            if (ci_r == 2'd2) begin
              ci_nxt    = 2'd0;
              state_nxt = ret_r;
            end else begin
              ci_nxt = ci_r + 2'd1;
            end
          end else begin
            tc_nxt = tc_r + 2'd1;
          end
        end
      end

      S_NLOAD: begin
        for (int i = 0; i < 3; i++) begin
          ns_nxt[i] = nv_r[i][47];
          na_nxt[i] = nv_r[i][47] ? 48'(-nv_r[i]) : 48'(nv_r[i]);
        end
        state_nxt = S_NSHIFT;
      end

      // bring the largest magnitude into [2^29, 2^30)
      S_NSHIFT: begin
        if (mx == 48'd0) begin
          nz_nxt = 1'b0;
          for (int i = 0; i < 3; i++) begin
            unique case (ndst_r)
              DST_HD:  hd_nxt[i] = '0;
              DST_UV:  uv_nxt[i] = '0;
              default: up_nxt[i] = '0;
            endcase
          end
          state_nxt = nret_r;
        end else if (|mx[47:38]) begin
          for (int i = 0; i < 3; i++) na_nxt[i] = na_r[i] >> 8;
        end else if (|mx[37:30]) begin
          for (int i = 0; i < 3; i++) na_nxt[i] = na_r[i] >> 1;
        end else if (mx[29:21] == 9'd0) begin
          for (int i = 0; i < 3; i++) na_nxt[i] = na_r[i] << 8;
        end else if (!mx[29]) begin
          for (int i = 0; i < 3; i++) na_nxt[i] = na_r[i] << 1;
        end else begin
          mop_nxt   = MOP_NSQ;
          ret_nxt   = S_NSQI;
          ci_nxt    = 2'd0;
          tc_nxt    = 2'd0;
          ph_nxt    = 1'b0;
          state_nxt = S_MAC;
        end
      end

      S_NSQI: begin
        sx_nxt    = acc_r;
        res_nxt   = '0;
        k_nxt     = 5'd31;
        state_nxt = S_NSQRT;
      end

      S_NSQRT: begin
        if (sx_r >= tsum) begin
          sx_nxt  = sx_r - tsum;
          res_nxt = (res_r >> 1) + bitv;
        end else begin
          res_nxt = res_r >> 1;
        end
        if (k_r == 5'd0) begin
          rr_nxt    = res_nxt[31:0];
          ci_nxt    = 2'd0;
          state_nxt = S_NDIVLD;
        end else begin
          k_nxt = k_r - 5'd1;
        end
      end

      // quotient fits in 15 bits, so the top of the numerator starts the remainder
      S_NDIVLD: begin
        rem_nxt   = 32'(nn[44:15]);
        nlo_nxt   = nn[14:0];
        q_nxt     = '0;
        j_nxt     = 4'd14;
        state_nxt = S_NDIV;
      end

      S_NDIV: begin
        rem_nxt     = ge ? 32'(rem2 - {1'b0, rr_r}) : rem2[31:0];
        q_nxt[j_r]  = ge;
        if (j_r == 4'd0) begin
          qv = {1'b0, q_nxt};
          wv = ns_r[ci_r] ? -signed'(qv) : signed'(qv);
          unique case (ndst_r)
            DST_HD:  hd_nxt[ci_r] = wv;
            DST_UV:  uv_nxt[ci_r] = wv;
            default: up_nxt[ci_r] = wv;
          endcase
          if (ci_r == 2'd2) begin
            nz_nxt    = 1'b1;
            ci_nxt    = 2'd0;
            state_nxt = nret_r;
          end else begin
            ci_nxt    = ci_r + 2'd1;
            state_nxt = S_NDIVLD;
          end
        end else begin
          j_nxt = j_r - 4'd1;
        end
      end

      S_FCAX: begin
        mop_nxt   = MOP_AXIS;
        ret_nxt   = S_FCAXN;
        ci_nxt    = 2'd0;
        tc_nxt    = 2'd0;
        ph_nxt    = 1'b0;
        state_nxt = S_MAC;
      end

      S_FCAXN: begin
        ndst_nxt  = DST_UP;
        nret_nxt  = S_PRED;
        state_nxt = S_NLOAD;
      end

      S_PRED: begin
        mop_nxt   = MOP_BLDV;
        ret_nxt   = S_PVN;
        ci_nxt    = 2'd0;
        tc_nxt    = 2'd0;
        ph_nxt    = 1'b0;
        state_nxt = S_MAC;
      end

      S_PVN: begin
        ndst_nxt  = DST_HD;
        nret_nxt  = S_PVFIX;
        state_nxt = S_NLOAD;
      end

      S_PVFIX: begin
        if (!nz_r) begin
          hfix[0] = '0;
          hfix[1] = '0;
          hfix[2] = cnpp_pkg::ONE_Q14;
        end
        for (int i = 0; i < 3; i++) hd_nxt[i] = hfix[i];
        if (cnt_r == 2'd3) begin
          mop_nxt   = MOP_BLDW;
          ret_nxt   = S_PWN;
          ci_nxt    = 2'd0;
          tc_nxt    = 2'd0;
          ph_nxt    = 1'b0;
          state_nxt = S_MAC;
        end else begin
          for (int i = 0; i < 3; i++) uv_nxt[i] = hfix[i];
          state_nxt = S_STEP;
        end
      end

      S_PWN: begin
        ndst_nxt  = DST_UV;
        nret_nxt  = S_PWFIX;
        state_nxt = S_NLOAD;
      end

      // zero offset: step along the heading
      S_PWFIX: begin
        if (!nz_r) begin
          for (int i = 0; i < 3; i++) uv_nxt[i] = hd_r[i];
        end
        state_nxt = S_STEP;
      end

      S_STEP: begin
        mop_nxt   = MOP_STEP;
        ret_nxt   = S_STEPFIN;
        ci_nxt    = 2'd0;
        tc_nxt    = 2'd0;
        ph_nxt    = 1'b0;
        state_nxt = S_MAC;
      end

      // round the step product half away from zero, then add with saturation
      S_STEPFIN: begin
        if (!ph_r) begin
          off_nxt = nv_r[ci_r][47] ? -22'(qr) : 22'(qr);
          ph_nxt  = 1'b1;
        end else begin
          ph_nxt = 1'b0;
          if (ssum > 34'sd2147483647) begin
            nx_nxt[ci_r] = 32'sh7FFFFFFF;
          end else if (ssum < -34'sd2147483648) begin
            nx_nxt[ci_r] = 32'sh80000000;
          end else begin
            nx_nxt[ci_r] = ssum[31:0];
          end
          if (ci_r == 2'd2) begin
            ci_nxt    = 2'd0;
            state_nxt = S_DOT;
          end else begin
            ci_nxt = ci_r + 2'd1;
          end
        end
      end

      S_DOT: begin
        mop_nxt   = MOP_DOT;
        ret_nxt   = S_UPV;
        ci_nxt    = 2'd0;
        tc_nxt    = 2'd0;
        ph_nxt    = 1'b0;
        state_nxt = S_MAC;
      end

      S_UPV: begin
        dot_nxt   = acc_r[31:0];
        mop_nxt   = MOP_UPV;
        ret_nxt   = S_UPSQ;
        ci_nxt    = 2'd0;
        tc_nxt    = 2'd0;
        ph_nxt    = 1'b0;
        state_nxt = S_MAC;
      end

      S_UPSQ: begin
        mop_nxt   = MOP_UPSQ;
        ret_nxt   = S_UPCHK;
        ci_nxt    = 2'd0;
        tc_nxt    = 2'd0;
        ph_nxt    = 1'b0;
        state_nxt = S_MAC;
      end

      // projection too short: fall back to a world axis
      S_UPCHK: begin
        if (acc_r > cnpp_pkg::UP_MIN_SQ) begin
          ndst_nxt  = DST_UP;
          nret_nxt  = S_OUT;
          state_nxt = S_NLOAD;
        end else begin
          mop_nxt   = MOP_AXIS;
          ret_nxt   = S_AXN;
          ci_nxt    = 2'd0;
          tc_nxt    = 2'd0;
          ph_nxt    = 1'b0;
          state_nxt = S_MAC;
        end
      end

      S_AXN: begin
        ndst_nxt  = DST_UP;
        nret_nxt  = S_OUT;
        state_nxt = S_NLOAD;
      end

      // hold until the output register is free
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_nxt.accepted         = racc_r;
          out_nxt.prediction_valid = rvld_r;
          out_nxt.next_x           = rvld_r ? nx_r[0] : '0;
          out_nxt.next_y           = rvld_r ? nx_r[1] : '0;
          out_nxt.next_z           = rvld_r ? nx_r[2] : '0;
          out_nxt.heading_x        = rvld_r ? hd_r[0] : '0;
          out_nxt.heading_y        = rvld_r ? hd_r[1] : '0;
          out_nxt.heading_z        = rvld_r ? hd_r[2] : '0;
          out_nxt.up_x             = rvld_r ? up_r[0] : '0;
          out_nxt.up_y             = rvld_r ? up_r[1] : '0;
          out_nxt.up_z             = rvld_r ? up_r[2] : '0;
          state_nxt                = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= cnpp_pkg::MODE_IDLE;
      cnt_r       <= 2'd0;
      step_r      <= cnpp_pkg::STEP_RESET;
      out_valid_r <= 1'b0;
      ph_r        <= 1'b0;
      ci_r        <= 2'd0;
      tc_r        <= 2'd0;
      for (int i = 0; i < 3; i++) begin
        seed_r[i] <= '0;
        up_r[i]   <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      cnt_r       <= cnt_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      ph_r        <= ph_nxt;
      ci_r        <= ci_nxt;
      tc_r        <= tc_nxt;
      for (int i = 0; i < 3; i++) begin
        seed_r[i] <= seed_nxt[i];
        up_r[i]   <= up_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    ret_r  <= ret_nxt;
    nret_r <= nret_nxt;
    mop_r  <= mop_nxt;
    ndst_r <= ndst_nxt;
    nz_r   <= nz_nxt;
    racc_r <= racc_nxt;
    rvld_r <= rvld_nxt;
    out_r  <= out_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    dot_r  <= dot_nxt;
    sx_r   <= sx_nxt;
    res_r  <= res_nxt;
    k_r    <= k_nxt;
    rr_r   <= rr_nxt;
    rem_r  <= rem_nxt;
    nlo_r  <= nlo_nxt;
    q_r    <= q_nxt;
    j_r    <= j_nxt;
    off_r  <= off_nxt;
    for (int i = 0; i < 3; i++) begin
      hd_r[i] <= hd_nxt[i];
      uv_r[i] <= uv_nxt[i];
      nx_r[i] <= nx_nxt[i];
      nv_r[i] <= nv_nxt[i];
      na_r[i] <= na_nxt[i];
      ns_r[i] <= ns_nxt[i];
    end
    for (int i = 0; i < cnpp_pkg::HIST_DEPTH; i++) begin
      hist_r[i] <= hist_nxt[i];
    end
  end

endmodule

[tb/tb_curve_next_point_predictor.sv]
// Testbench for curve_next_point_predictor: directed and random point streams.
// Depends on cnpp_pkg and the RTL top level; holds its own model of the predictor.
`timescale 1ns / 100ps

module tb_curve_next_point_predictor;
  import cnpp_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_wr_en = 1'b0;
  logic [STEP_W-1:0] cfg_wr_data = '0;

  curve_next_point_predictor dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always #2 clk = ~clk;

  // predictor state
  int unsigned step_len = STEP_RESET;
  logic [1:0]  cur_mode = MODE_IDLE;
  int unsigned n_pts = 0;
  int          hist[3][3];   // [axis][entry], oldest first
  int          seed_vec[3];
  int          up_vec[3];

  out_item_t   pending_q[$];
  int          mismatches = 0;
  int          rx_idle_pct = 0;
  int          tx_idle_pct = 0;
  int          rx_hold = 0;
  int          items_sent = 0;

  function automatic longint unsigned magn(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic bit unit_vec(input longint v[3], output int h[3]);
    longint unsigned a[3], m, s, r, q;
    m = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = magn(v[i]);
      if (a[i] > m) m = a[i];
      h[i] = 0;
    end
    if (m == 0) return 1'b0;
    while (m >= (64'd1 << 30)) begin
      m >>= 1;
      for (int i = 0; i < 3; i++) a[i] >>= 1;
    end
    while (m < (64'd1 << 29)) begin
      m <<= 1;
      for (int i = 0; i < 3; i++) a[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) s += a[i] * a[i];
    r = isqrt(s);
    for (int i = 0; i < 3; i++) begin
      q = (a[i] * 16384 + r / 2) / r;
      h[i] = v[i] < 0 ? -int'(q) : int'(q);
    end
    return 1'b1;
  endfunction

  function automatic int step_off(int base, int h);
    longint p, q, sum;
    p = longint'(h) * longint'(step_len);
    q = longint'((magn(p) + 32) >> 6);
    sum = longint'(base) + (p < 0 ? -q : q);
    if (sum > 64'sd2147483647) return 32'sh7fffffff;
    if (sum < -64'sd2147483648) return 32'sh80000000;
    return int'(sum);
  endfunction

  function automatic void axis_up(input int d[3], output int o[3]);
    longint v[3];
    int c;
    bit nz;
    c = (d[1] <= int'(AXIS_LIMIT) && d[1] >= -int'(AXIS_LIMIT)) ? 1 : 0;
    for (int i = 0; i < 3; i++)
      v[i] = (i == c ? longint'(ONE_Q28) : 64'sd0) - longint'(d[c]) * longint'(d[i]);
    nz = unit_vec(v, o);
  endfunction

  function automatic void refresh_up(input int d[3]);
    longint dot, v[3];
    longint unsigned sq, t;
    int o[3];
    bit nz;
    dot = 0;
    sq = 0;
    for (int i = 0; i < 3; i++) dot += longint'(up_vec[i]) * longint'(d[i]);
    for (int i = 0; i < 3; i++) begin
      v[i] = longint'(up_vec[i]) * (64'sd1 << 28) - dot * longint'(d[i]);
      t = magn(v[i]) >> 14;
      sq += t * t;
    end
    if (sq > 64'd65536) nz = unit_vec(v, o);
    else axis_up(d, o);
    up_vec = o;
  endfunction

  function automatic void next_point(output int nxt[3], output int h[3]);
    longint v[3], w[3];
    int u[3];
    int last;
    last = (n_pts - 1) % HIST_DEPTH;
    if (n_pts >= 3) begin
      for (int i = 0; i < 3; i++) begin
        v[i] = 3 * longint'(hist[i][0]) - 8 * longint'(hist[i][1]) + 5 * longint'(hist[i][2]);
        w[i] = longint'(hist[i][0]) - 3 * longint'(hist[i][1]) + 2 * longint'(hist[i][2]);
      end
      if (!unit_vec(v, h)) h = '{0, 0, 16384};
      if (!unit_vec(w, u)) u = h;
    end else begin
      for (int i = 0; i < 3; i++)
        v[i] = n_pts == 2 ? longint'(hist[i][1]) - longint'(hist[i][0])
                          : longint'(seed_vec[i]);
      if (!unit_vec(v, h)) h = '{0, 0, 16384};
      u = h;
    end
    for (int i = 0; i < 3; i++) nxt[i] = step_off(hist[i][last], u[i]);
    refresh_up(h);
  endfunction

  // Advance the model by one item and return the result it produces.
  function automatic out_item_t apply_item(in_item_t it);
    out_item_t o;
    bit acc, pv, nz;
    int nxt[3], h[3], d[3], pt[3];
    longint s[3];
    o = '0;
    acc = 0;
    pv = 0;
    case (it.operation)
      OP_BEGIN: begin
        cur_mode = MODE_WAIT;
        n_pts = 0;
        acc = 1;
      end
      OP_CLICK: begin
        if (it.primary_button && (cur_mode == MODE_WAIT || cur_mode == MODE_ANNOT)) begin
          if (cur_mode == MODE_WAIT) begin
            seed_vec = '{it.seed_normal_x, it.seed_normal_y, it.seed_normal_z};
            for (int i = 0; i < 3; i++) s[i] = seed_vec[i];
            nz = unit_vec(s, d);
            axis_up(d, up_vec);
            n_pts = 0;
            cur_mode = MODE_ANNOT;
          end
          pt = '{it.point_x, it.point_y, it.point_z};
          if (n_pts >= HIST_DEPTH) begin
            for (int i = 0; i < 3; i++) begin
              hist[i][0] = hist[i][1];
              hist[i][1] = hist[i][2];
            end
            n_pts = HIST_DEPTH - 1;
          end
          for (int i = 0; i < 3; i++) hist[i][n_pts] = pt[i];
          n_pts++;
          acc = 1;
          pv = 1;
        end
      end
      OP_REPREDICT: begin
        if (cur_mode == MODE_ANNOT && n_pts > 0) begin
          acc = 1;
          pv = 1;
        end
      end
      default: begin
        if (cur_mode == MODE_WAIT || cur_mode == MODE_ANNOT) begin
          cur_mode = MODE_IDLE;
          n_pts = 0;
          acc = 1;
        end
      end
    endcase
    o.accepted = acc;
    o.prediction_valid = pv;
    if (pv) begin
      next_point(nxt, h);
      o.next_x = nxt[0];
      o.next_y = nxt[1];
      o.next_z = nxt[2];
      o.heading_x = h[0];
      o.heading_y = h[1];
      o.heading_z = h[2];
      o.up_x = up_vec[0];
      o.up_y = up_vec[1];
      o.up_z = up_vec[2];
    end
    return o;
  endfunction

  // result side: check every transfer, then pick the next ready level
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_data);
        end else begin
          out_item_t e;
          e = pending_q.pop_front();
          if (out_data !== e) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch at %0t\n  expected %p\n  actual   %p", $realtime, e, out_data);
          end
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_item(in_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    pending_q.push_back(apply_item(it));
    items_sent++;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_q.size() != 0 && guard < 400000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
  endtask

  task automatic write_step(logic [STEP_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    step_len = v;
    @(posedge clk);
  endtask

  function automatic in_item_t mk(logic [1:0] op, bit prim, int px, int py, int pz,
                                  shortint sx, shortint sy, shortint sz);
    in_item_t it;
    it.operation = op;
    it.primary_button = prim;
    it.point_x = px;
    it.point_y = py;
    it.point_z = pz;
    it.seed_normal_x = sx;
    it.seed_normal_y = sy;
    it.seed_normal_z = sz;
    return it;
  endfunction

  function automatic int rand_coord(int prev);
    case ($urandom_range(9))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      2: return prev;
      3: return prev + int'($urandom_range(2000000)) - 1000000;
      default: return prev + int'($urandom_range(8192)) - 4096;
    endcase
  endfunction

  function automatic shortint rand_seed();
    case ($urandom_range(5))
      0: return 0;
      1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: return shortint'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    send_item(mk(OP_REPREDICT, 1, 0, 0, 0, 0, 0, 0));
    send_item(mk(OP_CLICK, 1, 5, 5, 5, 1, 1, 1));
    send_item(mk(OP_FINISH, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(OP_BEGIN, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(OP_REPREDICT, 1, 0, 0, 0, 0, 0, 0));
    send_item(mk(OP_CLICK, 0, 1, 2, 3, 100, 0, 0));
    // zero seed: heading falls back to +z
    send_item(mk(OP_CLICK, 1, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 0));
    // repeated points: zero direction with two, then three points
    send_item(mk(OP_CLICK, 1, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 0));
    send_item(mk(OP_CLICK, 1, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 0));
    send_item(mk(OP_CLICK, 1, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0, 0));
    send_item(mk(OP_REPREDICT, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(OP_CLICK, 0, 9, 9, 9, 0, 0, 0));
    send_item(mk(OP_FINISH, 1, 0, 0, 0, 0, 0, 0));
    send_item(mk(OP_BEGIN, 0, 0, 0, 0, 0, 0, 0));
    // seed close to Y: up falls back to the X axis
    send_item(mk(OP_CLICK, 1, 0, 0, 0, 0, 16'sh7fff, 0));
    send_item(mk(OP_CLICK, 1, 256, 512, -768, 0, 0, 0));
    send_item(mk(OP_CLICK, 1, 1024, 256, 0, 0, 0, 0));
    send_item(mk(OP_CLICK, 1, 2048, -4096, 100, 0, 0, 0));
    send_item(mk(OP_FINISH, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(OP_BEGIN, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(OP_BEGIN, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(OP_CLICK, 1, -1, 1, -1, 16'sh8000, 16'sh8000, 16'sh8000));
    send_item(mk(OP_CLICK, 1, 255, 0, 0, 0, 0, 0));
    send_item(mk(OP_REPREDICT, 1, 0, 0, 0, 0, 0, 0));
    send_item(mk(OP_FINISH, 0, 0, 0, 0, 0, 0, 0));
    drain();
  endtask

  // Mostly well-formed curves with random content; some noise items in between.
  task automatic test_random(int n);
    int target, px, py, pz, clicks;
    target = items_sent + n;
    px = 0;
    py = 0;
    pz = 0;
    while (items_sent < target) begin
      if ($urandom_range(9) == 0) begin
        send_item(in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom}));
      end else begin
        send_item(mk(OP_BEGIN, $urandom_range(1), $urandom, $urandom, $urandom, 0, 0, 0));
        clicks = $urandom_range(1, 7);
        for (int k = 0; k < clicks; k++) begin
          px = rand_coord(px);
          py = rand_coord(py);
          pz = rand_coord(pz);
          send_item(mk(OP_CLICK, $urandom_range(7) != 0, px, py, pz,
                       rand_seed(), rand_seed(), rand_seed()));
          if ($urandom_range(4) == 0)
            send_item(mk(OP_REPREDICT, $urandom_range(1), $urandom, 0, 0, 0, 0, 0));
        end
        if ($urandom_range(3) != 0)
          send_item(mk(OP_FINISH, $urandom_range(1), 0, 0, 0, 0, 0, 0));
      end
    end
    drain();
  endtask

  task automatic test_backpressure();
    rx_hold = 3000;
    test_random(12);
  endtask

  initial begin : main
    int guard;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();

    tx_idle_pct = 35;
    rx_idle_pct = 86;
    write_step(12'd0);
    test_random(90);
    write_step(12'd4095);
    test_random(90);

    tx_idle_pct = 86;
    rx_idle_pct = 35;
    write_step(12'd1);
    test_random(90);
    write_step(STEP_W'($urandom));
    test_random(90);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_backpressure();
    write_step(12'd10);
    test_random(90);
    write_step(12'd64);
    test_random(90);

    guard = 0;
    while (pending_q.size() != 0 && guard < 400000) begin
      @(posedge clk);
      guard++;
    end
    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #40000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
